// ===== src/u8d_pkg.sv =====
// Shared types and constants for the UTF-8 byte decoder.
package u8d_pkg;

    localparam int BYTE_W  = 8;
    localparam int CODE_W  = 31;
    localparam int PART_W  = 25;
    localparam int REM_W   = 3;
    localparam int CONT_W  = 6;
    localparam int STAT_W  = 2;

    localparam logic [1:0] CONT_TAG = 2'b10;

    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 2'd0,
        ST_BAD_LEAD = 2'd1,
        ST_BAD_CONT = 2'd2,
        ST_TRUNC    = 2'd3
    } status_t;

    typedef struct packed {
        logic [CODE_W-1:0] code_point;
        status_t           status;
    } result_t;

endpackage

// ===== src/u8d_decode.sv =====
// Decode step: sequence state plus the per-byte result logic.
module u8d_decode
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      item_valid,
    input  logic [u8d_pkg::BYTE_W-1:0] data_byte,
    input  logic                      end_of_input,
    output logic                      res_valid,
    output u8d_pkg::result_t          res
);
    import u8d_pkg::*;

    logic [REM_W-1:0]  rem_reg,  rem_next;
    logic [PART_W-1:0] part_reg, part_next;

    always_comb
    begin
        rem_next       = rem_reg;
        part_next      = part_reg;
        res_valid      = 1'b0;
        res.code_point = '0;
        res.status     = ST_OK;
        if (item_valid)
        begin
            if (end_of_input)
            begin
                if (rem_reg != '0)
                begin
                    res_valid  = 1'b1;
                    res.status = ST_TRUNC;
                    rem_next   = '0;
                    part_next  = '0;
                end
            end
            else if (rem_reg == '0)
            begin
                unique casez (data_byte)
                    8'b0???????:
                    begin
                        res_valid      = 1'b1;
                        res.code_point = CODE_W'(data_byte);
                    end
                    8'b110?????:
                    begin
                        part_next = PART_W'(data_byte[4:0]);
                        rem_next  = REM_W'(1);
                    end
                    8'b1110????:
                    begin
                        part_next = PART_W'(data_byte[3:0]);
                        rem_next  = REM_W'(2);
                    end
                    8'b11110???:
                    begin
                        part_next = PART_W'(data_byte[2:0]);
                        rem_next  = REM_W'(3);
                    end
                    8'b111110??:
                    begin
                        part_next = PART_W'(data_byte[1:0]);
                        rem_next  = REM_W'(4);
                    end
                    8'b1111110?:
                    begin
                        part_next = PART_W'(data_byte[0]);
                        rem_next  = REM_W'(5);
                    end
                    default:
                    begin
                        // 10xxxxxx or seven-plus leading ones
                        res_valid  = 1'b1;
                        res.status = ST_BAD_LEAD;
                        part_next  = '0;
                    end
                endcase
            end
            else if (data_byte[7:6] != CONT_TAG)
            begin
                res_valid  = 1'b1;
                res.status = ST_BAD_CONT;
                rem_next   = '0;
                part_next  = '0;
            end
            else if (rem_reg == REM_W'(1))
            begin
                res_valid      = 1'b1;
                res.code_point = {part_reg, data_byte[CONT_W-1:0]};
                rem_next       = '0;
                part_next      = '0;
            end
            else
            begin
                part_next = {part_reg[PART_W-CONT_W-1:0], data_byte[CONT_W-1:0]};
                rem_next  = rem_reg - REM_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg  <= '0;
            part_reg <= '0;
        end
        else
        begin
            rem_reg  <= rem_next;
            part_reg <= part_next;
        end
    end

endmodule

// ===== src/u8d_out_fifo.sv =====
// Two-entry result buffer between the decode step and the output channel.
module u8d_out_fifo
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  u8d_pkg::result_t push_data,
    output logic             full,
    output logic             out_valid,
    input  logic             out_stall,
    output u8d_pkg::result_t out_data
);
    import u8d_pkg::*;

    result_t    mem [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg,  count_next;
    logic       pop;

    assign full      = (count_reg == 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_data  = mem[rd_ptr_reg];
    assign pop       = out_valid && !out_stall;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== src/utf8_byte_decoder_top.sv =====
// Top level of the UTF-8 byte decoder: input register, decode step, result buffer.
// Decodes one byte per cycle while the input is not stalled; sequences of one to six
// bytes, code points up to 31 bits. Each transfer is taken into an input register,
// decoded against the sequence state once the result buffer is not full and, when it
// completes a character or shows an error, written into a two-entry result buffer.
// Input stalls only while the input register holds a byte and the buffer is full.
module utf8_byte_decoder_top
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [u8d_pkg::BYTE_W-1:0] data_byte,
    input  logic                       end_of_input,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [u8d_pkg::CODE_W-1:0] code_point,
    output logic [u8d_pkg::STAT_W-1:0] status
);
    import u8d_pkg::*;

    logic              in_valid_reg;
    logic [BYTE_W-1:0] data_reg;
    logic              end_reg;
    logic              fifo_full;
    logic              advance;
    logic              res_valid;
    result_t           res;
    result_t           out_data;

    assign in_stall = in_valid_reg && fifo_full;
    assign advance  = in_valid_reg && !fifo_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            data_reg <= data_byte;
            end_reg  <= end_of_input;
        end
    end

    u8d_decode u_decode
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (advance),
        .data_byte    (data_reg),
        .end_of_input (end_reg),
        .res_valid    (res_valid),
        .res          (res)
    );

    u8d_out_fifo u_out_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res),
        .full      (fifo_full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    assign code_point = out_data.code_point;
    assign status     = out_data.status;

endmodule

// ===== src/u8d_checker.sv =====
// Port-level checks for the UTF-8 byte decoder, bound to the top level.
module u8d_checker
(
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_stall,
    input logic                       out_valid,
    input logic                       out_stall,
    input logic [u8d_pkg::CODE_W-1:0] code_point,
    input logic [u8d_pkg::STAT_W-1:0] status
);
    import u8d_pkg::*;

    // errors never carry a code point
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != ST_OK) |-> code_point == '0)
        else $error("error result with nonzero code point");

    // input only stalls behind pending results
    a_stall_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with no pending result");

    // stall never held without a pending result
    a_stall_needs_in: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall && !out_valid |-> 1'b0)
        else $error("stall without pending result");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(code_point) && $stable(status))
        else $error("stalled result changed");

    // no result is present when reset is released
    a_rst_quiet: assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid)
        else $error("result present right after reset");

endmodule

bind utf8_byte_decoder_top u8d_checker u_chk (.*);
